/* design/shell_word_tokenizer_macros.svh */
// ============================================================================
// Shell word tokeniser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef SHELL_WORD_TOKENIZER_MACROS_SVH
`define SHELL_WORD_TOKENIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define SWT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed in the following cycle");

`endif

/* design/swt_pkg.sv */
// ============================================================================
// Shell word tokeniser package
// Beat types and character constants shared by the tokeniser modules.
// ============================================================================
package swt_pkg;

    typedef struct packed {
        logic [15:0] character;
        logic        last_of_command;
    } in_item_t;

    typedef struct packed {
        logic [20:0] word_char;
        logic        char_valid;
        logic        word_end;
        logic        command_end;
    } out_item_t;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        out_item_t [MAX_RESULTS-1:0] res;
        logic [1:0]                  cnt;
    } group_t;

    localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;
    localparam logic [20:0] STAR_CHAR      = 21'h00002A;
    localparam logic [20:0] ESC_CHAR       = 21'h00001B;
    localparam logic [20:0] DOLLAR_CHAR    = 21'h000024;
    localparam logic [20:0] BSLASH_CHAR    = 21'h00005C;

endpackage

/* design/swt_out.sv */
// ============================================================================
// Shell word tokeniser result register
// Holds the results of one character and hands them out one beat at a time.
// ============================================================================
module swt_out
    import swt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  group_t    group_in,
    output logic      free,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    group_t     grp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] rd_reg;
    logic       full_reg;
    logic       take;
    logic       last_take;

    assign take      = full_reg && !out_stall;
    assign last_take = take && (rd_reg == cnt_reg - 2'd1);
    assign free      = !full_reg || last_take;
    assign out_valid = full_reg;
    assign out_data  = grp_reg.res[rd_reg];

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            grp_reg <= group_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            rd_reg   <= 2'd0;
            full_reg <= 1'b0;
        end
        else if (load && free)
        begin
            cnt_reg  <= group_in.cnt;
            rd_reg   <= 2'd0;
            full_reg <= 1'b1;
        end
        else if (last_take)
        begin
            full_reg <= 1'b0;
        end
        else if (take)
        begin
            rd_reg <= rd_reg + 2'd1;
        end
    end

`include "shell_word_tokenizer_macros.svh"

    `SWT_ASSERT_NOW(a_load_only_when_free, load, free)
    `SWT_ASSERT_NOW(a_count_nonzero, full_reg, cnt_reg != 2'd0 && rd_reg < cnt_reg)
    `SWT_ASSERT_NOW(a_cmd_end_is_last, full_reg && out_data.command_end, rd_reg == cnt_reg - 2'd1)
    `SWT_ASSERT_NEXT(a_drain_empties, last_take && !load, !full_reg)

endmodule

/* design/swt_step.sv */
// ============================================================================
// Shell word tokeniser step logic
// Applies one character to the quoting and escape state and forms its results.
// ============================================================================
module swt_step
    import swt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     preserve,
    input  logic     fire,
    input  in_item_t item,
    output group_t   group_out
);

    localparam logic [1:0] Q_NONE    = 2'd0;
    localparam logic [1:0] Q_SINGLE  = 2'd1;
    localparam logic [1:0] Q_DOUBLE  = 2'd2;
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_LETTER = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;

    logic [1:0]  quote_reg,   quote_next;
    logic        cesc_reg,    cesc_next;
    logic [1:0]  phase_reg,   phase_next;
    logic [3:0]  max_reg,     max_next;
    logic [3:0]  cnt_reg,     cnt_next;
    logic [20:0] val_reg,     val_next;
    logic        ovf_reg,     ovf_next;
    logic        bs_reg,      bs_next;
    logic [20:0] held_reg,    held_next;
    logic        hv_reg,      hv_next;
    logic        ws_reg,      ws_next;

    function automatic logic [20:0] esc_result(logic [20:0] v, logic [3:0] c, logic o);
        if (c == 4'd0 || o || v == 21'd0)
        begin
            return STAR_CHAR;
        end
        return v;
    endfunction

    always_comb
    begin
        logic [15:0] ch;
        logic [20:0] chw;
        logic        last;
        logic        a1_en;
        logic [20:0] a1_ch;
        logic        run_plain;
        logic        p_app;
        logic [20:0] p_ch;
        logic        p_rm;
        logic        p_rm_ce;
        logic        p_end;
        logic [20:0] m;
        logic [3:0]  dval;
        logic        dok;
        logic        octal;
        logic [24:0] nv;
        logic [20:0] qc;
        logic [1:0]  rc;
        group_t      g;

        ch   = item.character;
        chw  = {5'd0, ch};
        last = item.last_of_command;

        quote_next = quote_reg;
        cesc_next  = cesc_reg;
        phase_next = phase_reg;
        max_next   = max_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        ovf_next   = ovf_reg;
        bs_next    = bs_reg;
        held_next  = held_reg;
        hv_next    = hv_reg;
        ws_next    = ws_reg;

        a1_en     = 1'b0;
        a1_ch     = 21'd0;
        run_plain = 1'b0;
        p_app     = 1'b0;
        p_ch      = chw;
        p_rm      = 1'b0;
        p_rm_ce   = 1'b0;
        p_end     = 1'b0;
        m         = chw;
        dval      = 4'd0;
        dok       = 1'b0;
        octal     = (max_reg == 4'd3);
        nv        = 25'd0;
        qc        = 21'h27;
        rc        = 2'd0;
        g         = '0;

        if (ch inside {[16'h30:16'h39]})
        begin
            dval = ch[3:0];
            dok  = 1'b1;
        end
        else if (ch inside {[16'h61:16'h66], [16'h41:16'h46]})
        begin
            dval = ch[3:0] + 4'd9;
            dok  = 1'b1;
        end

        if (phase_reg == PH_LETTER)
        begin
            case (ch)
                16'h61:  m = 21'd7;
                16'h62:  m = 21'd8;
                16'h65:  m = ESC_CHAR;
                16'h45:  m = ESC_CHAR;
                16'h66:  m = 21'd12;
                16'h6E:  m = 21'd10;
                16'h72:  m = 21'd13;
                16'h74:  m = 21'd9;
                16'h76:  m = 21'd11;
                default: m = chw;
            endcase
            val_next = 21'd0;
            cnt_next = 4'd0;
            ovf_next = 1'b0;
            phase_next = PH_DIGITS;
            if (ch == 16'h78)
            begin
                max_next = 4'd2;
            end
            else if (ch == 16'h75)
            begin
                max_next = 4'd4;
            end
            else if (ch == 16'h55)
            begin
                max_next = 4'd8;
            end
            else if (ch inside {[16'h30:16'h37]})
            begin
                max_next = 4'd3;
                val_next = {18'd0, ch[2:0]};
                cnt_next = 4'd1;
            end
            else
            begin
                phase_next = PH_IDLE;
                a1_en      = 1'b1;
                a1_ch      = m;
            end
            if (phase_next == PH_DIGITS && last)
            begin
                a1_en      = 1'b1;
                a1_ch      = esc_result(val_next, cnt_next, ovf_next);
                phase_next = PH_IDLE;
            end
        end
        else if (phase_reg == PH_DIGITS)
        begin
            if (dok && !(octal && dval[3]) && cnt_reg < max_reg)
            begin
                if (!ovf_reg)
                begin
                    nv = octal ? {1'b0, val_reg, 3'd0} : {val_reg, 4'd0};
                    nv = nv + {21'd0, dval};
                    if (nv > {4'd0, MAX_CODE_POINT})
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        val_next = nv[20:0];
                    end
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_next >= max_reg || last)
                begin
                    a1_en      = 1'b1;
                    a1_ch      = esc_result(val_next, cnt_next, ovf_next);
                    phase_next = PH_IDLE;
                end
            end
            else
            begin
                a1_en      = 1'b1;
                a1_ch      = esc_result(val_reg, cnt_reg, ovf_reg);
                phase_next = PH_IDLE;
                run_plain  = 1'b1;
            end
        end
        else if (bs_reg)
        begin
            bs_next = 1'b0;
            a1_en   = 1'b1;
            a1_ch   = chw;
        end
        else
        begin
            run_plain = 1'b1;
        end

        if (run_plain)
        begin
            if (quote_reg != Q_NONE)
            begin
                qc = (quote_reg == Q_SINGLE) ? 21'h27 : 21'h22;
                if (preserve)
                begin
                    p_app = 1'b1;
                end
                if (chw == qc)
                begin
                    quote_next = Q_NONE;
                    cesc_next  = 1'b0;
                end
                else if (cesc_reg && !preserve && chw == BSLASH_CHAR)
                begin
                    if (last)
                    begin
                        p_app = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_LETTER;
                    end
                end
                else if (!preserve)
                begin
                    p_app = 1'b1;
                end
            end
            else if (ch == 16'h27 || ch == 16'h22)
            begin
                if (preserve)
                begin
                    p_app = 1'b1;
                end
                else
                begin
                    p_rm    = 1'b1;
                    p_rm_ce = (ch == 16'h27);
                end
                quote_next = (ch == 16'h27) ? Q_SINGLE : Q_DOUBLE;
            end
            else if (chw == BSLASH_CHAR && !last)
            begin
                p_app   = preserve;
                bs_next = 1'b1;
            end
            else if (ch inside {[16'h09:16'h0D], 16'h20, 16'h85, 16'hA0, 16'h1680,
                                [16'h2000:16'h200A], 16'h2028, 16'h2029, 16'h202F,
                                16'h205F, 16'h3000})
            begin
                p_end = 1'b1;
            end
            else
            begin
                p_app = 1'b1;
            end
        end

        if (a1_en)
        begin
            if (hv_next)
            begin
                g.res[rc] = '{word_char: held_next, char_valid: 1'b1,
                              word_end: 1'b0, command_end: 1'b0};
                rc      = rc + 2'd1;
                ws_next = 1'b1;
            end
            held_next = a1_ch;
            hv_next   = 1'b1;
        end

        if (p_rm && hv_next && held_next == DOLLAR_CHAR)
        begin
            hv_next   = 1'b0;
            held_next = 21'd0;
            cesc_next = p_rm_ce;
        end

        if (p_app)
        begin
            if (hv_next)
            begin
                g.res[rc] = '{word_char: held_next, char_valid: 1'b1,
                              word_end: 1'b0, command_end: 1'b0};
                rc      = rc + 2'd1;
                ws_next = 1'b1;
            end
            held_next = p_ch;
            hv_next   = 1'b1;
        end

        if (p_end || last)
        begin
            if (hv_next)
            begin
                g.res[rc] = '{word_char: held_next, char_valid: 1'b1,
                              word_end: 1'b1, command_end: 1'b0};
                rc = rc + 2'd1;
            end
            else if (ws_next)
            begin
                g.res[rc] = '{word_char: 21'd0, char_valid: 1'b0,
                              word_end: 1'b1, command_end: 1'b0};
                rc = rc + 2'd1;
            end
            hv_next   = 1'b0;
            held_next = 21'd0;
            ws_next   = 1'b0;
        end

        if (last)
        begin
            if (rc == 2'd0)
            begin
                g.res[0] = '0;
                rc       = 2'd1;
            end
            g.res[rc - 2'd1].command_end = 1'b1;
            quote_next = Q_NONE;
            cesc_next  = 1'b0;
            phase_next = PH_IDLE;
            max_next   = 4'd0;
            cnt_next   = 4'd0;
            val_next   = 21'd0;
            ovf_next   = 1'b0;
            bs_next    = 1'b0;
        end

        g.cnt     = rc;
        group_out = g;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg <= Q_NONE;
            cesc_reg  <= 1'b0;
            phase_reg <= PH_IDLE;
            max_reg   <= 4'd0;
            cnt_reg   <= 4'd0;
            val_reg   <= 21'd0;
            ovf_reg   <= 1'b0;
            bs_reg    <= 1'b0;
            held_reg  <= 21'd0;
            hv_reg    <= 1'b0;
            ws_reg    <= 1'b0;
        end
        else if (fire)
        begin
            quote_reg <= quote_next;
            cesc_reg  <= cesc_next;
            phase_reg <= phase_next;
            max_reg   <= max_next;
            cnt_reg   <= cnt_next;
            val_reg   <= val_next;
            ovf_reg   <= ovf_next;
            bs_reg    <= bs_next;
            held_reg  <= held_next;
            hv_reg    <= hv_next;
            ws_reg    <= ws_next;
        end
    end

endmodule

/* design/shell_word_tokenizer.sv */
// ============================================================================
// Shell word tokeniser
// Splits a command text into shell-like words, one character beat in.
// ============================================================================
// One 16-bit character is taken per cycle into an input register unless in_stall
// holds it; the step logic then applies it to the quoting state and loads its
// zero to three results into the result register, which hands them out one beat
// per cycle while out_stall is low. The next character waits in the input
// register until the last result beat of the one before it is taken.
module shell_word_tokenizer
    import swt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_write,
    input  logic      cfg_data,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic     preserve_reg;
    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     free;
    logic     fire;
    logic     load;
    group_t   group;

    assign fire     = in_valid_reg && free;
    assign load     = fire && (group.cnt != 2'd0);
    assign in_stall = in_valid_reg && !free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preserve_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            preserve_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
    end

    swt_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .preserve  (preserve_reg),
        .fire      (fire),
        .item      (in_item_reg),
        .group_out (group)
    );

    swt_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .group_in  (group),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* tb/testbench.sv */
// ============================================================================
// Shell word tokeniser testbench
// Sends command characters as beats, predicts the word character beats that
// each one should produce and checks every result beat against the oldest
// prediction. Directed commands come first, then random commands under
// several idling mixes and both syntax modes.
// ============================================================================
module testbench
    import swt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {QUOTE_NONE, QUOTE_SINGLE, QUOTE_DOUBLE} quote_e;
    typedef enum logic [1:0] {ESC_IDLE, ESC_LETTER, ESC_DIGITS} escape_e;

    localparam logic [15:0] CH_SQUOTE = 16'h0027;
    localparam logic [15:0] CH_DQUOTE = 16'h0022;
    localparam int QUIET_LIMIT = 1000;
    localparam int REPORT_LIMIT = 10;
    localparam string HEX_DIGITS = "0123456789abcdefABCDEF";
    localparam string SIMPLE_ESCAPES = "abeEfnrtvq\\'\"";
    localparam logic [15:0] BLANKS [0:12] = '{16'h0009, 16'h000A, 16'h000B, 16'h000C,
        16'h000D, 16'h0020, 16'h0085, 16'h00A0, 16'h1680, 16'h2005, 16'h2028,
        16'h202F, 16'h3000};

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_write = 1'b0;
    logic      cfg_data = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int chars_sent = 0;
    int commands_sent = 0;
    int beats_checked = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    logic        keep_syntax = 1'b0;
    quote_e      quote_kind = QUOTE_NONE;
    logic        ansi_quote = 1'b0;
    escape_e     esc_phase = ESC_IDLE;
    logic [3:0]  esc_limit = '0;
    logic [3:0]  esc_count = '0;
    logic [21:0] esc_val = '0;
    logic        esc_ovf = 1'b0;
    logic        bs_pending = 1'b0;
    logic [20:0] hold_ch = '0;
    logic        hold_vld = 1'b0;
    logic        word_begun = 1'b0;

    out_item_t   step_beats[$];
    out_item_t   pending_beats[$];
    logic [15:0] cmd_text[$];

    shell_word_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void put_beat(logic [20:0] ch, logic vld, logic wend);
        out_item_t beat;
        beat = '{word_char: ch, char_valid: vld, word_end: wend, command_end: 1'b0};
        if (step_beats.size() < MAX_RESULTS)
            step_beats.push_back(beat);
    endfunction

    function automatic void add_char(logic [20:0] ch);
        if (hold_vld)
        begin
            put_beat(hold_ch, 1'b1, 1'b0);
            word_begun = 1'b1;
        end
        hold_ch = ch;
        hold_vld = 1'b1;
    endfunction

    function automatic void close_word();
        if (hold_vld)
            put_beat(hold_ch, 1'b1, 1'b1);
        else if (word_begun)
            put_beat('0, 1'b0, 1'b1);
        hold_vld = 1'b0;
        hold_ch = '0;
        word_begun = 1'b0;
    endfunction

    function automatic bit is_blank(logic [15:0] ch);
        return (ch >= 16'h0009 && ch <= 16'h000D) || ch == 16'h0020 || ch == 16'h0085 ||
               ch == 16'h00A0 || ch == 16'h1680 || (ch >= 16'h2000 && ch <= 16'h200A) ||
               ch == 16'h2028 || ch == 16'h2029 || ch == 16'h202F || ch == 16'h205F ||
               ch == 16'h3000;
    endfunction

    function automatic int hex_value(logic [15:0] ch);
        if (ch >= 16'h0030 && ch <= 16'h0039)
            return int'(ch) - 'h30;
        if (ch >= 16'h0061 && ch <= 16'h0066)
            return int'(ch) - 'h61 + 10;
        if (ch >= 16'h0041 && ch <= 16'h0046)
            return int'(ch) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void close_escape();
        if (esc_count == 0 || esc_ovf || esc_val == 0)
            add_char(STAR_CHAR);
        else
            add_char(esc_val[20:0]);
        esc_phase = ESC_IDLE;
    endfunction

    function automatic void begin_escape(logic [15:0] ch, bit last);
        logic [20:0] mapped;
        mapped = 21'(ch);
        case (ch)
            "a": mapped = 21'd7;
            "b": mapped = 21'd8;
            "e", "E": mapped = ESC_CHAR;
            "f": mapped = 21'd12;
            "n": mapped = 21'd10;
            "r": mapped = 21'd13;
            "t": mapped = 21'd9;
            "v": mapped = 21'd11;
            default: ;
        endcase
        esc_val = '0;
        esc_count = '0;
        esc_ovf = 1'b0;
        if (ch == "x")
            esc_limit = 4'd2;
        else if (ch == "u")
            esc_limit = 4'd4;
        else if (ch == "U")
            esc_limit = 4'd8;
        else if (ch >= 16'h0030 && ch <= 16'h0037)
        begin
            esc_limit = 4'd3;
            esc_val = 22'(ch - 16'h0030);
            esc_count = 4'd1;
        end
        else
        begin
            esc_phase = ESC_IDLE;
            add_char(mapped);
            return;
        end
        esc_phase = ESC_DIGITS;
        if (last)
            close_escape();
    endfunction

    function automatic void plain_char(logic [15:0] ch, bit last);
        logic [15:0] closer;
        if (quote_kind != QUOTE_NONE)
        begin
            closer = (quote_kind == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
            if (keep_syntax)
                add_char(21'(ch));
            if (ch == closer)
            begin
                quote_kind = QUOTE_NONE;
                ansi_quote = 1'b0;
            end
            else if (ansi_quote && !keep_syntax && ch == BSLASH_CHAR[15:0])
            begin
                if (last)
                    add_char(BSLASH_CHAR);
                else
                    esc_phase = ESC_LETTER;
            end
            else if (!keep_syntax)
                add_char(21'(ch));
            return;
        end
        if (ch == CH_SQUOTE || ch == CH_DQUOTE)
        begin
            if (keep_syntax)
                add_char(21'(ch));
            else if (hold_vld && hold_ch == DOLLAR_CHAR)
            begin
                hold_vld = 1'b0;
                hold_ch = '0;
                ansi_quote = (ch == CH_SQUOTE);
            end
            quote_kind = (ch == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
            return;
        end
        if (ch == BSLASH_CHAR[15:0] && !last)
        begin
            if (keep_syntax)
                add_char(21'(ch));
            bs_pending = 1'b1;
            return;
        end
        if (is_blank(ch))
        begin
            close_word();
            return;
        end
        add_char(21'(ch));
    endfunction

    function automatic void predict_beats(in_item_t item);
        logic [15:0] ch;
        bit last;
        int digit;
        bit octal;
        int unsigned next_val;
        out_item_t tail;
        ch = item.character;
        last = item.last_of_command;
        step_beats.delete();
        if (esc_phase == ESC_LETTER)
            begin_escape(ch, last);
        else if (esc_phase == ESC_DIGITS)
        begin
            digit = hex_value(ch);
            octal = (esc_limit == 4'd3);
            if (digit >= 0 && !(octal && digit >= 8) && esc_count < esc_limit)
            begin
                if (!esc_ovf)
                begin
                    next_val = esc_val * (octal ? 32'd8 : 32'd16) + 32'(digit);
                    if (next_val > MAX_CODE_POINT)
                        esc_ovf = 1'b1;
                    else
                        esc_val = next_val[21:0];
                end
                esc_count++;
                if (esc_count >= esc_limit || last)
                    close_escape();
            end
            else
            begin
                close_escape();
                plain_char(ch, last);
            end
        end
        else if (bs_pending)
        begin
            bs_pending = 1'b0;
            add_char(21'(ch));
        end
        else
            plain_char(ch, last);

        if (last)
        begin
            close_word();
            if (step_beats.size() == 0)
                put_beat('0, 1'b0, 1'b0);
            tail = step_beats.pop_back();
            tail.command_end = 1'b1;
            step_beats.push_back(tail);
            quote_kind = QUOTE_NONE;
            ansi_quote = 1'b0;
            esc_phase = ESC_IDLE;
            esc_limit = '0;
            esc_count = '0;
            esc_val = '0;
            esc_ovf = 1'b0;
            bs_pending = 1'b0;
        end
        foreach (step_beats[i])
            pending_beats.push_back(step_beats[i]);
    endfunction

    function automatic void check_beat(out_item_t got);
        out_item_t want;
        beats_checked++;
        if (pending_beats.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: unexpected result beat: char %h valid %b word_end %b cmd_end %b",
                         $time, got.word_char, got.char_valid, got.word_end, got.command_end);
            return;
        end
        want = pending_beats.pop_front();
        if (got.word_char !== want.word_char || got.char_valid !== want.char_valid ||
            got.word_end !== want.word_end || got.command_end !== want.command_end)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("%0t: expected char %h valid %b word_end %b cmd_end %b",
                         $time, want.word_char, want.char_valid, want.word_end,
                         want.command_end);
                $display("%0t:      got char %h valid %b word_end %b cmd_end %b",
                         $time, got.word_char, got.char_valid, got.word_end, got.command_end);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && out_valid && !out_stall)
            check_beat(out_data);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_char(logic [15:0] ch, bit last);
        in_item_t item;
        item = '{character: ch, last_of_command: last};
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_data <= item;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_beats(item);
        chars_sent++;
    endtask

    task automatic send_text(string text);
        for (int i = 0; i < text.len(); i++)
            send_char(16'(text[i]), i == text.len() - 1);
        commands_sent++;
    endtask

    task automatic wait_drain(int extra);
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_syntax_mode(bit keep);
        wait_drain(8);
        cfg_data <= keep;
        cfg_write <= 1'b1;
        @(posedge clk);
        keep_syntax = keep;
        cfg_write <= 1'b0;
    endtask

    function automatic logic [15:0] pick_plain();
        case ($urandom_range(0, 7))
            0: return 16'($urandom_range(0, 16'hFFFF));
            1: return DOLLAR_CHAR[15:0];
            2: return 16'($urandom_range(16'h0030, 16'h0039));
            default: return 16'($urandom_range(16'h0061, 16'h007A));
        endcase
    endfunction

    function automatic logic [15:0] pick_inner();
        case ($urandom_range(0, 5))
            0: return BLANKS[$urandom_range(0, 12)];
            1: return CH_SQUOTE;
            2: return CH_DQUOTE;
            3: return BSLASH_CHAR[15:0];
            default: return pick_plain();
        endcase
    endfunction

    function automatic void add_hex_digits(int count);
        for (int i = 0; i < count; i++)
            cmd_text.push_back(16'(HEX_DIGITS[$urandom_range(0, 21)]));
    endfunction

    function automatic void add_escape();
        string pattern;
        cmd_text.push_back(BSLASH_CHAR[15:0]);
        case ($urandom_range(0, 6))
            0, 1: cmd_text.push_back(16'(SIMPLE_ESCAPES[$urandom_range(0, 12)]));
            2:
            begin
                cmd_text.push_back("x");
                add_hex_digits($urandom_range(0, 3));
            end
            3:
            begin
                cmd_text.push_back("u");
                add_hex_digits($urandom_range(0, 5));
            end
            4:
            begin
                cmd_text.push_back("U");
                case ($urandom_range(0, 3))
                    0: pattern = "0010FFFF";
                    1: pattern = "00110000";
                    2: pattern = "0001F600";
                    default: pattern = "";
                endcase
                if (pattern.len() == 0)
                    add_hex_digits($urandom_range(0, 9));
                else
                    for (int i = 0; i < pattern.len(); i++)
                        cmd_text.push_back(16'(pattern[i]));
            end
            5:
            begin
                cmd_text.push_back(16'($urandom_range(16'h0030, 16'h0037)));
                for (int i = $urandom_range(0, 3); i > 0; i--)
                    cmd_text.push_back(16'($urandom_range(16'h0030, 16'h0039)));
            end
            default: cmd_text.push_back(16'($urandom_range(0, 16'hFFFF)));
        endcase
    endfunction

    function automatic void build_command();
        int cut;
        logic [15:0] opener;
        cmd_text.delete();
        for (int tok = $urandom_range(1, 5); tok > 0; tok--)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    for (int i = $urandom_range(1, 3); i > 0; i--)
                        cmd_text.push_back(pick_plain());
                2: cmd_text.push_back(BLANKS[$urandom_range(0, 12)]);
                3:
                begin
                    cmd_text.push_back(BSLASH_CHAR[15:0]);
                    cmd_text.push_back(pick_inner());
                end
                4, 5:
                begin
                    cmd_text.push_back(DOLLAR_CHAR[15:0]);
                    cmd_text.push_back(CH_SQUOTE);
                    for (int i = $urandom_range(1, 3); i > 0; i--)
                        if ($urandom_range(0, 3) == 0)
                            cmd_text.push_back(pick_plain());
                        else
                            add_escape();
                    cmd_text.push_back(CH_SQUOTE);
                end
                6, 7:
                begin
                    if ($urandom_range(0, 1) == 1)
                        cmd_text.push_back(DOLLAR_CHAR[15:0]);
                    opener = ($urandom_range(0, 1) == 1) ? CH_SQUOTE : CH_DQUOTE;
                    cmd_text.push_back(opener);
                    for (int i = $urandom_range(0, 3); i > 0; i--)
                        cmd_text.push_back(pick_inner());
                    cmd_text.push_back(opener);
                end
                default:
                    for (int i = $urandom_range(1, 3); i > 0; i--)
                        cmd_text.push_back(16'($urandom_range(0, 16'hFFFF)));
            endcase
        end
        if ($urandom_range(0, 7) == 0)
        begin
            cut = $urandom_range(1, cmd_text.size());
            while (cmd_text.size() > cut)
                void'(cmd_text.pop_back());
        end
    endfunction

    task automatic send_command();
        foreach (cmd_text[i])
            send_char(cmd_text[i], i == cmd_text.size() - 1);
        commands_sent++;
    endtask

    task automatic test_edge_characters();
        set_syntax_mode(1'b0);
        send_char(16'h0000, 1'b1);
        send_char(16'hFFFF, 1'b0);
        send_char(16'h3000, 1'b0);
        send_char(16'h0020, 1'b1);
        commands_sent += 2;
    endtask

    task automatic test_quoting();
        set_syntax_mode(1'b0);
        send_text("a$''");
        send_text("$$\"b");
        send_text("c\\");
    endtask

    task automatic test_escapes();
        set_syntax_mode(1'b0);
        send_text("$'\\x4");
        send_text("$'\\n'");
    endtask

    task automatic test_preserve_mode();
        set_syntax_mode(1'b1);
        send_text("$'x\\\"");
    endtask

    task automatic test_random_commands(bit keep, int idle, int stall, int target);
        int start_count;
        bit paused;
        set_syntax_mode(keep);
        send_idle_pct = idle;
        stall_pct = stall;
        start_count = chars_sent;
        paused = 1'b0;
        while (chars_sent - start_count < target)
        begin
            build_command();
            send_command();
            if (!paused && chars_sent - start_count >= target / 2)
            begin
                wait_drain(1);
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_characters();
        test_quoting();
        test_escapes();
        test_preserve_mode();
        test_random_commands(1'b0, 0, 0, 35);
        test_random_commands(1'b1, 74, 0, 35);
        test_random_commands(1'b0, 0, 74, 35);
        test_random_commands(1'b1, 18, 18, 35);

        wait_drain(8);
        $display("Covered %0d characters in %0d commands, both syntax modes, four idling mixes;",
                 chars_sent, commands_sent);
        $display("%0d result beats checked, %0d mismatches.", beats_checked, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
